### design/cbe_pkg.sv
// Shared types, widths and constants for the cubic Bezier easing pipeline.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package cbe_pkg;

    // Bisection depth and internal fraction width of t, u and basis terms
    localparam int BISECT_STEPS = 12;
    localparam int FRAC_BITS    = 16;

    // Fixed Q16 formats of the ports and control registers
    localparam int CTRL_FRAC = 16;
    localparam int X_W       = 17;   // clamped progress / ctrl_x, unsigned Q16
    localparam int Y_W       = 19;   // ctrl_y and eased result, signed Q16
    localparam int PROG_W    = 18;   // progress input, signed Q16
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    // Derived datapath widths
    localparam int T_W  = FRAC_BITS + 1;       // t, u, truncated products (0..one)
    localparam int B_W  = FRAC_BITS + 2;       // 3 * product (0..3*one)
    localparam int XP_W = B_W + X_W;           // basis times ctrl_x
    localparam int XS_W = XP_W + 2;            // x(t) sum
    localparam int YP_W = B_W + Y_W + 1;       // signed basis times ctrl_y
    localparam int YS_W = YP_W + 2;            // y(t) sum
    localparam int YR_W = YS_W - FRAC_BITS;    // y(t) after rounding to Q16

    localparam logic [T_W-1:0] T_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [X_W-1:0] X_ONE   = {1'b1, {CTRL_FRAC{1'b0}}};
    localparam logic [T_W-1:0] T_FINAL = T_ONE >> BISECT_STEPS;

    localparam int OUT_MIN = -131072;
    localparam int OUT_MAX = 196608;

    // Reset values of the control points
    localparam logic [X_W-1:0] X1_RESET = '0;
    localparam logic [Y_W-1:0] Y1_RESET = '0;
    localparam logic [X_W-1:0] X2_RESET = {1'b1, {CTRL_FRAC{1'b0}}};
    localparam logic [Y_W-1:0] Y2_RESET = {3'b001, {CTRL_FRAC{1'b0}}};

    // Register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CTRL_X1 = 8'd0,
        REG_CTRL_Y1 = 8'd1,
        REG_CTRL_X2 = 8'd2,
        REG_CTRL_Y2 = 8'd3
    } cfg_reg_e;

    // Control points as seen by the datapath
    typedef struct packed {
        logic [X_W-1:0]        x1;
        logic signed [Y_W-1:0] y1;
        logic [X_W-1:0]        x2;
        logic signed [Y_W-1:0] y2;
    } ctrl_pts_t;

    // Word state that travels down the bisection chain
    typedef struct packed {
        logic           valid;
        logic [X_W-1:0] x;
        logic [T_W-1:0] lo;
        logic [T_W-1:0] hi;
    } step_ctl_t;

endpackage

`default_nettype wire

### design/cbe_basis.sv
// Two-stage Bernstein basis unit: B1 = 3*u*u*t, B2 = 3*u*t*t, B3 = t*t*t.
// Depends on cbe_pkg. Datapath only; the caller carries valid alongside.
`default_nettype none

module cbe_basis (
    input  wire logic                        aclk,
    input  wire logic                        adv,
    input  wire logic [cbe_pkg::T_W-1:0]     t,
    output logic      [cbe_pkg::B_W-1:0]     b1,
    output logic      [cbe_pkg::B_W-1:0]     b2,
    output logic      [cbe_pkg::T_W-1:0]     b3
);

    localparam int TW = cbe_pkg::T_W;
    localparam int BW = cbe_pkg::B_W;
    localparam int F  = cbe_pkg::FRAC_BITS;

    logic [TW-1:0]   u;
    logic [2*TW-1:0] uu_full, ut_full, tt_full;
    logic [TW-1:0]   uu_reg, ut_reg, tt_reg, td_reg;
    logic [2*TW-1:0] uut_full, utt_full, ttt_full;
    logic [TW-1:0]   uut, utt;
    logic [BW-1:0]   b1_next, b2_next;
    logic [BW-1:0]   b1_reg, b2_reg;
    logic [TW-1:0]   b3_reg;

    // First products, truncated to the fraction width
    assign u       = cbe_pkg::T_ONE - t;
    assign uu_full = (2*TW)'(u) * (2*TW)'(u);
    assign ut_full = (2*TW)'(u) * (2*TW)'(t);
    assign tt_full = (2*TW)'(t) * (2*TW)'(t);

    always_ff @(posedge aclk) begin
        if (adv) begin
            uu_reg <= uu_full[F +: TW];
            ut_reg <= ut_full[F +: TW];
            tt_reg <= tt_full[F +: TW];
            td_reg <= t;
        end
    end

    // Second products times t, then scale by three
    assign uut_full = (2*TW)'(uu_reg) * (2*TW)'(td_reg);
    assign utt_full = (2*TW)'(ut_reg) * (2*TW)'(td_reg);
    assign ttt_full = (2*TW)'(tt_reg) * (2*TW)'(td_reg);
    assign uut      = uut_full[F +: TW];
    assign utt      = utt_full[F +: TW];
    assign b1_next  = (BW'(uut) << 1) + BW'(uut);
    assign b2_next  = (BW'(utt) << 1) + BW'(utt);

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            b3_reg <= ttt_full[F +: TW];
        end
    end

    assign b1 = b1_reg;
    assign b2 = b2_reg;
    assign b3 = b3_reg;

endmodule

`default_nettype wire

### design/cbe_bisect_step.sv
// One bisection step over four register stages: midpoint and basis (two),
// weighting by the x control points, then sum, compare and bracket update.
// Depends on cbe_pkg and cbe_basis.
`default_nettype none

module cbe_bisect_step (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  adv,
    input  wire cbe_pkg::ctrl_pts_t    pts,
    input  wire cbe_pkg::step_ctl_t    in_ctl,
    output cbe_pkg::step_ctl_t         out_ctl
);

    localparam int TW  = cbe_pkg::T_W;
    localparam int BW  = cbe_pkg::B_W;
    localparam int XPW = cbe_pkg::XP_W;
    localparam int XSW = cbe_pkg::XS_W;
    localparam int F   = cbe_pkg::FRAC_BITS;

    logic [TW:0]          mid_sum;
    logic [TW-1:0]        t;
    logic [BW-1:0]        b1, b2;
    logic [TW-1:0]        b3;
    cbe_pkg::step_ctl_t   c1_reg, c2_reg, c3_reg, out_reg, out_next;
    logic [TW-1:0]        t1_reg, t2_reg, t3_reg;
    logic [XPW-1:0]       px1_reg, px2_reg, px3_reg;
    logic [XSW-1:0]       bx, target;

    // Midpoint of the bracket
    assign mid_sum = {1'b0, in_ctl.lo} + {1'b0, in_ctl.hi};
    assign t       = mid_sum[TW:1];

    cbe_basis u_basis (
        .aclk (aclk),
        .adv  (adv),
        .t    (t),
        .b1   (b1),
        .b2   (b2),
        .b3   (b3)
    );

    // Carry the word state past the basis unit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg.valid <= 1'b0;
            c2_reg.valid <= 1'b0;
            c3_reg.valid <= 1'b0;
        end else if (adv) begin
            c1_reg <= in_ctl;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg <= t;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
        end
    end

    // Weight the basis terms by the x control points
    always_ff @(posedge aclk) begin
        if (adv) begin
            px1_reg <= XPW'(b1) * XPW'(pts.x1);
            px2_reg <= XPW'(b2) * XPW'(pts.x2);
            px3_reg <= XPW'({b3, {cbe_pkg::CTRL_FRAC{1'b0}}});
        end
    end

    // Compare x(t) against the target and shrink the bracket
    assign bx     = XSW'(px1_reg) + XSW'(px2_reg) + XSW'(px3_reg);
    assign target = XSW'({c3_reg.x, {F{1'b0}}});

    always_comb begin
        out_next = c3_reg;
        if (bx < target) begin
            out_next.lo = t3_reg;
        end else begin
            out_next.hi = t3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (adv) begin
            out_reg <= out_next;
        end
    end

    assign out_ctl = out_reg;

    // The bracket never inverts
    a_bracket_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_reg.valid |-> (out_reg.lo <= out_reg.hi))
        else $error("bisection bracket inverted");

endmodule

`default_nettype wire

### design/cbe_y_eval.sv
// Final evaluation of y(t) at the bracket midpoint over four register stages,
// with round-to-nearest to Q16 and saturation. Depends on cbe_pkg, cbe_basis.
`default_nettype none

module cbe_y_eval (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          adv,
    input  wire cbe_pkg::ctrl_pts_t            pts,
    input  wire cbe_pkg::step_ctl_t            in_ctl,
    output logic                               out_valid,
    output logic signed [cbe_pkg::Y_W-1:0]     out_y
);

    localparam int TW  = cbe_pkg::T_W;
    localparam int BW  = cbe_pkg::B_W;
    localparam int YW  = cbe_pkg::Y_W;
    localparam int YPW = cbe_pkg::YP_W;
    localparam int YSW = cbe_pkg::YS_W;
    localparam int YRW = cbe_pkg::YR_W;
    localparam int F   = cbe_pkg::FRAC_BITS;

    logic [TW:0]              mid_sum;
    logic [TW-1:0]            t;
    logic [BW-1:0]            b1, b2;
    logic [TW-1:0]            b3;
    logic                     v1_reg, v2_reg, v3_reg, valid_reg;
    logic signed [YPW-1:0]    py1_reg, py2_reg, py3_reg;
    logic signed [YSW-1:0]    ys, ys_rnd;
    logic signed [YRW-1:0]    yr;
    logic signed [YW-1:0]     y_next, y_reg;

    // Midpoint of the final bracket
    assign mid_sum = {1'b0, in_ctl.lo} + {1'b0, in_ctl.hi};
    assign t       = mid_sum[TW:1];

    cbe_basis u_basis (
        .aclk (aclk),
        .adv  (adv),
        .t    (t),
        .b1   (b1),
        .b2   (b2),
        .b3   (b3)
    );

    // Advance valid past the basis and weighting stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_ctl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Weight the basis terms by the y control points (signed)
    always_ff @(posedge aclk) begin
        if (adv) begin
            py1_reg <= YPW'($signed({1'b0, b1})) * YPW'(pts.y1);
            py2_reg <= YPW'($signed({1'b0, b2})) * YPW'(pts.y2);
            py3_reg <= $signed(YPW'({b3, {cbe_pkg::CTRL_FRAC{1'b0}}}));
        end
    end

    // Sum, round half up to Q16, saturate
    assign ys     = YSW'(py1_reg) + YSW'(py2_reg) + YSW'(py3_reg);
    assign ys_rnd = ys + $signed(YSW'({1'b1, {(F-1){1'b0}}}));
    assign yr     = ys_rnd[YSW-1:F];

    always_comb begin
        if (yr < YRW'(cbe_pkg::OUT_MIN)) begin
            y_next = YW'(cbe_pkg::OUT_MIN);
        end else if (yr > YRW'(cbe_pkg::OUT_MAX)) begin
            y_next = YW'(cbe_pkg::OUT_MAX);
        end else begin
            y_next = yr[YW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_reg <= y_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_y     = y_reg;

endmodule

`default_nettype wire

### design/cubic_bezier_easing_top.sv
// Cubic Bezier easing: clamp, BISECT_STEPS bisection steps, y evaluation.
// The clamped progress is registered before the first bisection step.
// Throughput: one word per cycle; the whole pipeline holds while the result
// register is full and not taken. Reset (aresetn, synchronous, active low)
// empties the pipeline and loads the control points to the linear curve.
// Depends on cbe_pkg, cbe_bisect_step, cbe_y_eval.
`default_nettype none

module cubic_bezier_easing_top (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [cbe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [cbe_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // progress input
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [cbe_pkg::PROG_W-1:0]    s_progress_in,
    // eased result
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [cbe_pkg::Y_W-1:0]            m_eased_out
);

    localparam int XW = cbe_pkg::X_W;
    localparam int YW = cbe_pkg::Y_W;
    localparam int NS = cbe_pkg::BISECT_STEPS;

    logic                  adv;
    logic [XW-1:0]         ctrl_x1_reg, ctrl_x2_reg;
    logic signed [YW-1:0]  ctrl_y1_reg, ctrl_y2_reg;
    cbe_pkg::ctrl_pts_t    pts;
    cbe_pkg::step_ctl_t    in_next, in_reg;
    cbe_pkg::step_ctl_t    chain [NS+1];
    logic [XW-1:0]         x_clamp;

    // Hold everything while the result word waits
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_x1_reg <= cbe_pkg::X1_RESET;
            ctrl_y1_reg <= cbe_pkg::Y1_RESET;
            ctrl_x2_reg <= cbe_pkg::X2_RESET;
            ctrl_y2_reg <= cbe_pkg::Y2_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cbe_pkg::REG_CTRL_X1: ctrl_x1_reg <= cfg_wdata[XW-1:0];
                cbe_pkg::REG_CTRL_Y1: ctrl_y1_reg <= cfg_wdata[YW-1:0];
                cbe_pkg::REG_CTRL_X2: ctrl_x2_reg <= cfg_wdata[XW-1:0];
                cbe_pkg::REG_CTRL_Y2: ctrl_y2_reg <= cfg_wdata[YW-1:0];
                default: ;
            endcase
        end
    end

    assign pts.x1 = ctrl_x1_reg;
    assign pts.y1 = ctrl_y1_reg;
    assign pts.x2 = ctrl_x2_reg;
    assign pts.y2 = ctrl_y2_reg;

    // Clamp progress to 0..one and open the bracket
    always_comb begin
        if (s_progress_in[cbe_pkg::PROG_W-1]) begin
            x_clamp = '0;
        end else if (s_progress_in > $signed(cbe_pkg::PROG_W'(cbe_pkg::X_ONE))) begin
            x_clamp = cbe_pkg::X_ONE;
        end else begin
            x_clamp = s_progress_in[XW-1:0];
        end
        in_next.valid = s_valid;
        in_next.x     = x_clamp;
        in_next.lo    = '0;
        in_next.hi    = cbe_pkg::T_ONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.valid <= 1'b0;
        end else if (adv) begin
            in_reg <= in_next;
        end
    end

    assign chain[0] = in_reg;

    // Bisection chain
    for (genvar i = 0; i < NS; i++) begin : g_step
        cbe_bisect_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .pts     (pts),
            .in_ctl  (chain[i]),
            .out_ctl (chain[i+1])
        );
    end

    // Evaluate y at the final midpoint; its output register is the result word
    cbe_y_eval u_y_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .pts       (pts),
        .in_ctl    (chain[NS]),
        .out_valid (m_valid),
        .out_y     (m_eased_out)
    );

    // Clamped progress stays within 0..one
    a_clamp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_reg.valid |-> (in_reg.x <= cbe_pkg::X_ONE))
        else $error("clamped progress out of range");

    // The bracket has halved once per step by the end of the chain
    a_final_width: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[NS].valid |-> ((chain[NS].hi - chain[NS].lo) == cbe_pkg::T_FINAL))
        else $error("final bracket width wrong");

    // A held pipeline keeps the last step's word
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(chain[NS]))
        else $error("bisection chain moved during stall");

    // A write to ctrl_x1 lands in its register
    a_cfg_x1: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_index == cbe_pkg::REG_CTRL_X1)
        |=> (ctrl_x1_reg == $past(cfg_wdata[XW-1:0])))
        else $error("ctrl_x1 write lost");

endmodule

`default_nettype wire
